// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked assertions with a reset disable. Each macro expects
// signals named clk and rst_n where it is used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FTPT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ftpt assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FTPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ftpt assertion failed");

`endif

// File: sv/ftpt_pkg.sv
// ----------------------------------------------------------------------------
// ftpt_pkg
// Sizes, codes and shared types of the first-touch page translator.
// ----------------------------------------------------------------------------
package ftpt_pkg;

    localparam int CONTEXTS_LOG2  = 2;
    localparam int ENTRIES_LOG2   = 8;
    localparam int PHYS_ADDR_BITS = 48;

    localparam int CTX_W     = (CONTEXTS_LOG2 > 0) ? CONTEXTS_LOG2 : 1;
    localparam int NUM_CTX   = 1 << CONTEXTS_LOG2;
    localparam int ADDR_W    = CONTEXTS_LOG2 + ENTRIES_LOG2;
    localparam int DEPTH     = 1 << ADDR_W;
    localparam int VPN_W     = 63;
    localparam int STRIDE_W  = 48;
    localparam int OFF_W     = STRIDE_W + CTX_W;
    localparam int TOP_SHIFT = PHYS_ADDR_BITS - CONTEXTS_LOG2;
    localparam int LG_W      = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [ENTRIES_LOG2-1:0] MAX_PAGES = '1;

    localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE_LOG2 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONTEXT_STRIDE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHARE_INSTR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHARE_DATA     = 3'd4;

    localparam logic CMD_INSTR = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    localparam logic [1:0] ST_HIT   = 2'd0;
    localparam logic [1:0] ST_ALLOC = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_COMPOSE,
        S_OUT
    } state_t;

    // Request from the controller to the address composer.
    typedef struct packed {
        logic                    start;
        logic [CTX_W-1:0]        ctx;
        logic [ENTRIES_LOG2-1:0] idx;
        logic [63:0]             in_page;
        logic [LG_W-1:0]         lg;
    } compose_req_t;

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [CTX_W-1:0] ctx,
                                                   input logic [ENTRIES_LOG2-1:0] idx);
        logic [ADDR_W-1:0] c;
        c = (CONTEXTS_LOG2 > 0) ? ADDR_W'(ctx) : '0;
        return (c << ENTRIES_LOG2) | ADDR_W'(idx);
    endfunction

endpackage

// File: sv/first_touch_page_translator_unit.sv
// ----------------------------------------------------------------------------
// first_touch_page_translator_unit
// Per-context first-touch page allocation and address translation.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  in        in_valid/in_stall    command, context_req, virtual_address
//  out       out_valid/out_stall  physical_address, status
//  cfg       cfg_write            cfg_index, cfg_data
//
// A miss scans all pages the selected context holds (none to 254) and then
// allocates the next entry; a hit on entry i ends the scan once entry i is
// read, and a full table is scanned in full and returns a zero address.
// The page table is scanned one entry per cycle through the RAM read port, and
// the next transaction is accepted in the cycle after a result is loaded.
// Reset clears the per-context counts at once; the page RAM needs no clearing.
// A new transaction is taken while a finished result waits on out_stall.
// ----------------------------------------------------------------------------
module first_touch_page_translator_unit
    import ftpt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 command,
    input  logic [1:0]           context_req,
    input  logic [63:0]          virtual_address,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [63:0]          physical_address,
    output logic [1:0]           status
);

    // Configuration registers.
    logic [LG_W-1:0]     page_size_log2_reg;
    logic [63:0]         base_address_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic                share_instr_reg;
    logic                share_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_size_log2_reg <= LG_W'(12);
            base_address_reg   <= '0;
            stride_reg         <= '0;
            share_instr_reg    <= 1'b0;
            share_data_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PAGE_SIZE_LOG2: page_size_log2_reg <= cfg_data[LG_W-1:0];
                REG_BASE_ADDRESS:   base_address_reg   <= cfg_data;
                REG_CONTEXT_STRIDE: stride_reg         <= cfg_data[STRIDE_W-1:0];
                REG_SHARE_INSTR:    share_instr_reg    <= cfg_data[0];
                REG_SHARE_DATA:     share_data_reg     <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // Control and datapath registers.
    state_t                  state_reg, state_next;
    logic [ENTRIES_LOG2-1:0] count_reg [NUM_CTX];
    logic [CTX_W-1:0]        ctx_reg;
    logic [VPN_W-1:0]        vpn_reg;
    logic [63:0]             in_page_reg;
    logic [LG_W-1:0]         lg_reg;
    logic [ENTRIES_LOG2-1:0] cnt_reg;
    logic [ENTRIES_LOG2-1:0] issue_idx_reg, issue_idx_next;
    logic                    pend_vld_reg, pend_vld_next;
    logic [ENTRIES_LOG2-1:0] pend_idx_reg;
    logic                    hit_reg, hit_next;
    logic [ENTRIES_LOG2-1:0] hit_idx_reg, hit_idx_next;
    logic [1:0]              status_reg, status_next;
    logic                    out_valid_reg, out_valid_next;
    logic [63:0]             pa_out_reg;
    logic [1:0]              status_out_reg;

    logic                    accept;
    logic [CTX_W-1:0]        ctx_in;
    logic [LG_W-1:0]         lg_in;
    logic                    issue;
    logic                    match;
    logic                    load_out;
    logic                    alloc;
    logic [VPN_W-1:0]        ram_rdata;
    compose_req_t            creq;
    logic                    comp_done;
    logic [63:0]             comp_pa;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        ctx_in = (CONTEXTS_LOG2 > 0) ? CTX_W'(context_req) : '0;
        if ((command == CMD_INSTR && share_instr_reg) ||
            (command == CMD_DATA && share_data_reg))
        begin
            ctx_in = '0;
        end
    end

    // A page size of zero behaves as two bytes.
    assign lg_in = (page_size_log2_reg == '0) ? LG_W'(1) : page_size_log2_reg;

    assign issue = (state_reg == S_SCAN) && (issue_idx_reg < cnt_reg);
    assign match = pend_vld_reg && (ram_rdata == vpn_reg);
    assign alloc = (state_reg == S_UPDATE) && !hit_reg && (cnt_reg != MAX_PAGES);

    ftpt_ram #(
        .WIDTH (VPN_W),
        .DEPTH (DEPTH)
    ) u_page_ram (
        .clk   (clk),
        .we    (alloc),
        .waddr (mem_addr(ctx_reg, cnt_reg)),
        .wdata (vpn_reg),
        .raddr (mem_addr(ctx_reg, issue_idx_reg)),
        .rdata (ram_rdata)
    );

    assign creq.start   = (state_reg == S_UPDATE) && (hit_reg || alloc);
    assign creq.ctx     = ctx_reg;
    assign creq.idx     = hit_reg ? hit_idx_reg : cnt_reg;
    assign creq.in_page = in_page_reg;
    assign creq.lg      = lg_reg;

    ftpt_compose u_compose (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (creq),
        .stride (stride_reg),
        .base   (base_address_reg),
        .done   (comp_done),
        .pa     (comp_pa)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        issue_idx_next = issue_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        status_next    = status_reg;
        load_out       = 1'b0;
        pend_vld_next  = issue;
        if (issue)
        begin
            issue_idx_next = issue_idx_reg + 1'b1;
        end
        case (state_reg)
            S_IDLE:
            begin
                issue_idx_next = '0;
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // Read data arrives in the cycle after its address is issued.
                if (match)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = pend_idx_reg;
                    state_next   = S_UPDATE;
                end
                else if (!issue && !pend_vld_reg)
                begin
                    hit_next   = 1'b0;
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if (hit_reg)
                begin
                    status_next = ST_HIT;
                    state_next  = S_COMPOSE;
                end
                else if (alloc)
                begin
                    status_next = ST_ALLOC;
                    state_next  = S_COMPOSE;
                end
                else
                begin
                    status_next = ST_FULL;
                    state_next  = S_OUT;
                end
            end
            S_COMPOSE:
            begin
                if (comp_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_vld_reg  <= 1'b0;
            for (int c = 0; c < NUM_CTX; c++)
            begin
                count_reg[c] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_vld_reg  <= pend_vld_next;
            if (alloc)
            begin
                count_reg[ctx_reg] <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctx_reg     <= ctx_in;
            lg_reg      <= lg_in;
            vpn_reg     <= VPN_W'(virtual_address >> lg_in);
            in_page_reg <= virtual_address & ((64'd1 << lg_in) - 64'd1);
            cnt_reg     <= count_reg[ctx_in];
        end
        issue_idx_reg <= issue_idx_next;
        pend_idx_reg  <= issue_idx_reg;
        hit_reg       <= hit_next;
        hit_idx_reg   <= hit_idx_next;
        status_reg    <= status_next;
        if (load_out)
        begin
            pa_out_reg     <= (status_reg == ST_FULL) ? 64'd0 : comp_pa;
            status_out_reg <= status_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign physical_address = pa_out_reg;
    assign status           = status_out_reg;

endmodule

// File: sv/ftpt_ram.sv
// ----------------------------------------------------------------------------
// ftpt_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ftpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/ftpt_compose.sv
// ----------------------------------------------------------------------------
// ftpt_compose
// Three-stage pipeline that builds the physical address from the entry index,
// the context offset, the in-page offset, the context top bits and the base.
// ----------------------------------------------------------------------------
module ftpt_compose
    import ftpt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  compose_req_t        req,
    input  logic [STRIDE_W-1:0] stride,
    input  logic [63:0]         base,
    output logic                done,
    output logic [63:0]         pa
);

    logic                    v1_reg, v2_reg, v3_reg;
    logic [OFF_W-1:0]        off_reg;
    logic [ENTRIES_LOG2-1:0] idx_reg;
    logic [63:0]             in_page_reg;
    logic [CTX_W-1:0]        ctx_reg;
    logic [LG_W-1:0]         lg_reg;
    logic [63:0]             sh_reg;
    logic [63:0]             pa_reg;

    logic [OFF_W-1:0] off_next;
    logic [63:0]      page;
    logic [63:0]      ctx_top;

    // Context times stride as a sum of shifted strides.
    always_comb
    begin
        off_next = '0;
        for (int b = 0; b < CTX_W; b++)
        begin
            if (req.ctx[b])
            begin
                off_next = off_next + (OFF_W'(stride) << b);
            end
        end
    end

    assign page    = 64'(off_reg) + 64'(idx_reg);
    assign ctx_top = (CONTEXTS_LOG2 > 0) ? (64'(ctx_reg) << TOP_SHIFT) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= req.start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            off_reg     <= off_next;
            idx_reg     <= req.idx;
            in_page_reg <= req.in_page;
            ctx_reg     <= req.ctx;
            lg_reg      <= req.lg;
        end
        if (v1_reg)
        begin
            sh_reg <= (page << lg_reg) | in_page_reg | ctx_top;
        end
        if (v2_reg)
        begin
            pa_reg <= sh_reg + base;
        end
    end

    assign done = v3_reg;
    assign pa   = pa_reg;

endmodule

// File: sv/ftpt_checker.sv
// ----------------------------------------------------------------------------
// ftpt_checker
// Port-level checks of the translator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ftpt_checker
    import ftpt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] physical_address,
    input logic [1:0]  status
);

    // A full table reports a zero address.
    `FTPT_ASSERT_SAME(a_full_zero, out_valid && status == ST_FULL, physical_address == 64'd0)

    // Only one transaction is in flight: an accept makes the input busy.
    `FTPT_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall)

    // A new result appears only after the input side was busy with it.
    `FTPT_ASSERT_SAME(a_result_after_work, $rose(out_valid), $past(in_stall))

    // A stalled result holds.
    `FTPT_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                      out_valid && $stable(physical_address) && $stable(status))

endmodule

bind first_touch_page_translator_unit ftpt_checker u_ftpt_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .physical_address (physical_address),
    .status           (status)
);
